// File: rtl/core/fcts_pkg.sv
// Shared constants, kind codes and signature tables for the content type sniffer.
package fcts_pkg;

  localparam int SAMPLE_MAX = 4096;

  localparam int CNT_W  = 13;
  localparam int PCT_W  = 7;
  localparam int PROD_W = CNT_W + PCT_W;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  localparam logic [2:0] KIND_JPEG        = 3'd0;
  localparam logic [2:0] KIND_PNG         = 3'd1;
  localparam logic [2:0] KIND_PDF         = 3'd2;
  localparam logic [2:0] KIND_TEXT        = 3'd3;
  localparam logic [2:0] KIND_UNSUPPORTED = 3'd4;

  localparam logic [1:0] REG_PDF_SCAN    = 2'd0;
  localparam logic [1:0] REG_TEXT_SAMPLE = 2'd1;
  localparam logic [1:0] REG_TEXT_PCT    = 2'd2;

  localparam logic [CNT_W-1:0] PDF_SCAN_RST    = 13'd1024;
  localparam logic [CNT_W-1:0] TEXT_SAMPLE_RST = 13'd4096;
  localparam logic [PCT_W-1:0] TEXT_PCT_RST    = 7'd5;

  // "%PDF" as the four bytes ahead of the closing dash
  localparam logic [31:0] PDF_STEM = 32'h2550_4446;
  localparam logic [7:0]  PDF_DASH = 8'h2D;

  localparam logic [PCT_W-1:0] PERCENT_SCALE = 7'd100;

  function automatic logic [7:0] jpeg_head(input logic [1:0] i);
    logic [7:0] v;
    unique case (i)
      2'd0:    v = 8'hFF;
      2'd1:    v = 8'hD8;
      default: v = 8'hFF;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] png_head(input logic [2:0] i);
    logic [7:0] v;
    unique case (i)
      3'd0: v = 8'h89;
      3'd1: v = 8'h50;
      3'd2: v = 8'h4E;
      3'd3: v = 8'h47;
      3'd4: v = 8'h0D;
      3'd5: v = 8'h0A;
      3'd6: v = 8'h1A;
      3'd7: v = 8'h0A;
    endcase
    return v;
  endfunction

  // Bytes below TAB, or between CR and space exclusive
  function automatic logic is_control(input logic [7:0] b);
    return (b < 8'h09) || ((b > 8'h0D) && (b < 8'h20));
  endfunction

endpackage

// File: rtl/core/file_content_type_sniffer.sv
// Content type sniffer: classifies a byte stream as JPEG, PNG, PDF, text or unsupported.
// Result: the kind for a file is loaded into the result register and shown on out_valid
//   at the edge at which its last byte leaves the input register.
// Throughput: one word per cycle while the result register is not stalled; the only loop is the per-byte state update.
// Backpressure: in_ready drops while the input register holds a word and a result sits unaccepted.
// Reset (rst_n low, synchronous): scan state cleared, registers back to defaults.
module file_content_type_sniffer
  import fcts_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_data_byte,
  input  logic                  in_last_byte,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [2:0]            out_content_kind,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [CNT_W-1:0]      cfg_data
);

  // Configuration registers
  logic [CNT_W-1:0] pdf_scan_r, text_sample_r;
  logic [PCT_W-1:0] text_pct_r;

  // Input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;

  // Scan state for the current file
  logic [CNT_W-1:0] byte_count_r, byte_count_nxt;
  logic             jpeg_ok_r, jpeg_ok_nxt;
  logic             png_ok_r, png_ok_nxt;
  logic [31:0]      recent_r, recent_nxt;
  logic             pdf_found_r, pdf_found_nxt;
  logic             nul_seen_r, nul_seen_nxt;
  logic [CNT_W-1:0] ctrl_count_r, ctrl_count_nxt;

  // Result register
  logic       out_valid_r, out_valid_nxt;
  logic [2:0] kind_r, kind_nxt;

  logic             s1_fire;
  logic [CNT_W-1:0] slim;
  logic [CNT_W-1:0] total, sample;
  logic [PROD_W-1:0] ctrl_prod, pct_prod;
  logic [2:0]       kind_calc;

  // The word in the input register moves on when the result register is free
  // or is being emptied this cycle.
  assign s1_fire  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_fire;

  assign out_valid        = out_valid_r;
  assign out_content_kind = kind_r;

  always_comb begin
    if (int'(text_sample_r) > SAMPLE_MAX) begin
      slim = CNT_W'(SAMPLE_MAX);
    end else begin
      slim = text_sample_r;
    end
  end

  // Per-byte update of the scan state
  always_comb begin
    jpeg_ok_nxt    = jpeg_ok_r;
    png_ok_nxt     = png_ok_r;
    pdf_found_nxt  = pdf_found_r;
    nul_seen_nxt   = nul_seen_r;
    ctrl_count_nxt = ctrl_count_r;

    if (byte_count_r < CNT_W'(3) && s1_byte_r != jpeg_head(byte_count_r[1:0])) begin
      jpeg_ok_nxt = 1'b0;
    end
    if (byte_count_r < CNT_W'(8) && s1_byte_r != png_head(byte_count_r[2:0])) begin
      png_ok_nxt = 1'b0;
    end

    // Marker start offset is four behind the dash
    if (byte_count_r >= CNT_W'(4) && byte_count_r < COUNT_MAX &&
        recent_r == PDF_STEM && s1_byte_r == PDF_DASH &&
        (byte_count_r - CNT_W'(4)) < pdf_scan_r) begin
      pdf_found_nxt = 1'b1;
    end

    if (byte_count_r < COUNT_MAX && byte_count_r < slim) begin
      if (s1_byte_r == 8'h00) begin
        nul_seen_nxt = 1'b1;
      end else if (is_control(s1_byte_r) && ctrl_count_r < COUNT_MAX) begin
        ctrl_count_nxt = ctrl_count_r + CNT_W'(1);
      end
    end

    recent_nxt = {recent_r[23:0], s1_byte_r};
    if (byte_count_r < COUNT_MAX) begin
      byte_count_nxt = byte_count_r + CNT_W'(1);
    end else begin
      byte_count_nxt = byte_count_r;
    end
  end

  // Classification on the updated state
  always_comb begin
    total     = byte_count_nxt;
    sample    = (total < slim) ? total : slim;
    ctrl_prod = PROD_W'(ctrl_count_nxt) * PROD_W'(PERCENT_SCALE);
    pct_prod  = PROD_W'(text_pct_r) * PROD_W'(sample);
    priority if (jpeg_ok_nxt && total >= CNT_W'(3)) begin
      kind_calc = KIND_JPEG;
    end else if (png_ok_nxt && total >= CNT_W'(8)) begin
      kind_calc = KIND_PNG;
    end else if (pdf_found_nxt) begin
      kind_calc = KIND_PDF;
    end else if (!nul_seen_nxt && ctrl_prod < pct_prod) begin
      kind_calc = KIND_TEXT;
    end else begin
      kind_calc = KIND_UNSUPPORTED;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    kind_nxt      = kind_r;
    if (s1_fire && s1_last_r) begin
      out_valid_nxt = 1'b1;
      kind_nxt      = kind_calc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pdf_scan_r    <= PDF_SCAN_RST;
      text_sample_r <= TEXT_SAMPLE_RST;
      text_pct_r    <= TEXT_PCT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PDF_SCAN:    pdf_scan_r    <= cfg_data;
        REG_TEXT_SAMPLE: text_sample_r <= cfg_data;
        REG_TEXT_PCT:    text_pct_r    <= cfg_data[PCT_W-1:0];
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      jpeg_ok_r    <= 1'b1;
      png_ok_r     <= 1'b1;
      recent_r     <= '0;
      pdf_found_r  <= 1'b0;
      nul_seen_r   <= 1'b0;
      ctrl_count_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (s1_fire) begin
        if (s1_last_r) begin
          // end of file: fresh scan for the next word
          byte_count_r <= '0;
          jpeg_ok_r    <= 1'b1;
          png_ok_r     <= 1'b1;
          recent_r     <= '0;
          pdf_found_r  <= 1'b0;
          nul_seen_r   <= 1'b0;
          ctrl_count_r <= '0;
        end else begin
          byte_count_r <= byte_count_nxt;
          jpeg_ok_r    <= jpeg_ok_nxt;
          png_ok_r     <= png_ok_nxt;
          recent_r     <= recent_nxt;
          pdf_found_r  <= pdf_found_nxt;
          nul_seen_r   <= nul_seen_nxt;
          ctrl_count_r <= ctrl_count_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
  end

endmodule

// File: rtl/core/fcts_checker.sv
// Port-level assertions for the content type sniffer, bound to the top level.
module fcts_checker
  import fcts_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [2:0]       out_content_kind
);

  // A stalled result holds its word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_content_kind))
    else $error("result word changed while stalled");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_content_kind <= KIND_UNSUPPORTED)
    else $error("kind code out of range");

  // Input stalls only behind a result waiting at the output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind file_content_type_sniffer fcts_checker u_fcts_checker (.*);
